FILE: hw/rtl/base64_point_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the base64 point decoder
// Shorthand for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_POINT_DECODER_CORE_ASSERT_SVH
`define BASE64_POINT_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64PD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("base64 point decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define B64PD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base64 point decoder check failed");

`endif

FILE: hw/rtl/b64pd_pkg.sv
// ----------------------------------------------------------------------------
// Base64 point decoder package
// Shared constants, the character map and the types passed between the
// front and back halves of the decoder.
// ----------------------------------------------------------------------------
package b64pd_pkg;

   localparam int CHAR_W      = 8;
   localparam int SEXTET_W    = 6;
   localparam int GROUP_CHARS = 16;
   localparam int STORE_DEPTH = GROUP_CHARS - 1;
   localparam int POS_W       = 4;
   localparam int WORD_W      = 32;
   localparam int WORDS_OUT   = 3;
   localparam int GROUP_BITS  = WORD_W * WORDS_OUT;
   localparam int QUAD_BITS   = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(STORE_DEPTH);

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;

   localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd26;
   localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd52;
   localparam logic [CHAR_W-1:0] PLUS_CODE  = 8'd62;
   localparam logic [CHAR_W-1:0] SLASH_CODE = 8'd63;

   typedef struct packed {
      logic                  valid;
      logic [GROUP_BITS-1:0] bytes;
   } group_push_type;

   typedef struct packed {
      logic push_ready;
      logic drained;
   } back_stat_type;

   function automatic logic [SEXTET_W-1:0] char_to_sextet(input logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] v;
      v = '0;
      case (code) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: v = code - CHAR_UPPER_A;
         [CHAR_LOWER_A:CHAR_LOWER_Z]: v = code - CHAR_LOWER_A + LOWER_BASE;
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: v = code - CHAR_DIGIT_0 + DIGIT_BASE;
         CHAR_PLUS:                   v = PLUS_CODE;
         CHAR_SLASH:                  v = SLASH_CODE;
         default:                     v = '0;
      endcase
      return v[SEXTET_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/base64_point_decoder_core.sv
// ----------------------------------------------------------------------------
// Base64 point decoder core
// Flow: accepting the sixteenth character of a group writes the group into
// the group queue; it moves on to the output register once that is free.
// Throughput: one character per cycle while the queue has room; one point per
// sixteen characters, set by the single-character front end and a two-entry group queue.
// Reset: synchronous; clears the group position, the queue pointers and count, and the
// output valid flag. The sextet store, queue contents and output words are not cleared.
// ----------------------------------------------------------------------------
`include "base64_point_decoder_core_assert.svh"

module base64_point_decoder_core #(
   parameter int COORDS_PER_POINT = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [b64pd_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                            req_message_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [b64pd_pkg::WORD_W-1:0]    rsp_x_bits,
   output logic [b64pd_pkg::WORD_W-1:0]    rsp_y_bits,
   output logic [b64pd_pkg::WORD_W-1:0]    rsp_z_bits
);
   import b64pd_pkg::*;

   group_push_type push;
   back_stat_type  stat;

   b64pd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_message_end (req_message_end),
      .back_stat       (stat),
      .push_out        (push)
   );

   b64pd_back #(
      .COORDS_PER_POINT (COORDS_PER_POINT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .back_stat  (stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_x_bits (rsp_x_bits),
      .rsp_y_bits (rsp_y_bits),
      .rsp_z_bits (rsp_z_bits)
   );

   // A finished group is only pushed when the queue has room for it.
   `B64PD_ASSERT_IMP(a_push_fits, clock, reset, push.valid, stat.push_ready)
   // A pushed group is held somewhere in the back end on the next cycle.
   `B64PD_ASSERT_NXT(a_push_held, clock, reset, push.valid, !stat.drained)

endmodule

FILE: hw/rtl/b64pd_front.sv
// ----------------------------------------------------------------------------
// Base64 point decoder front end
// Accepts characters, maps them to sextets, collects a group of sixteen and
// pushes the assembled twelve bytes into the queue.
// ----------------------------------------------------------------------------
module b64pd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [b64pd_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                            req_message_end,
   input  b64pd_pkg::back_stat_type        back_stat,
   output b64pd_pkg::group_push_type       push_out
);
   import b64pd_pkg::*;

   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [SEXTET_W-1:0] store_ff [STORE_DEPTH];
   logic [SEXTET_W-1:0] sextet;
   logic                accept;
   logic                group_done;
   logic [SEXTET_W-1:0] all_sextets [GROUP_CHARS];
   logic [GROUP_BITS-1:0] group_bytes;

   assign sextet     = char_to_sextet(req_char_code);
   assign req_ready  = (pos_ff != LAST_POS) || back_stat.push_ready;
   assign accept     = req_valid && req_ready;
   assign group_done = (pos_ff == LAST_POS);

   always_comb begin
      if (req_message_end || group_done) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !group_done) begin
         store_ff[pos_ff] <= sextet;
      end
   end

   // Each run of four sextets yields three bytes, most significant first,
   // placed at ascending byte positions of the little-endian group word.
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         all_sextets[i] = store_ff[i];
      end
      all_sextets[GROUP_CHARS-1] = sextet;
      for (int q = 0; q < GROUP_CHARS / 4; q++) begin
         group_bytes[QUAD_BITS*q +: QUAD_BITS] =
            {all_sextets[4*q+2][1:0], all_sextets[4*q+3][5:0],
             all_sextets[4*q+1][3:0], all_sextets[4*q+2][5:2],
             all_sextets[4*q][5:0],   all_sextets[4*q+1][5:4]};
      end
   end

   assign push_out.valid = accept && group_done;
   assign push_out.bytes = group_bytes;

endmodule

FILE: hw/rtl/b64pd_back.sv
// ----------------------------------------------------------------------------
// Base64 point decoder back end
// Queues finished groups and presents them as points in an output register,
// zeroing the words beyond the configured coordinate count.
// ----------------------------------------------------------------------------
module b64pd_back #(
   parameter int COORDS_PER_POINT = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  b64pd_pkg::group_push_type       push_in,
   output b64pd_pkg::back_stat_type        back_stat,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [b64pd_pkg::WORD_W-1:0]    rsp_x_bits,
   output logic [b64pd_pkg::WORD_W-1:0]    rsp_y_bits,
   output logic [b64pd_pkg::WORD_W-1:0]    rsp_z_bits
);
   import b64pd_pkg::*;

   localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

   logic [GROUP_BITS-1:0] queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff;
   logic [QCNT_W-1:0]     count_in;
   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     words_ff [WORDS_OUT];
   logic                  push;
   logic                  pop;

   assign push = push_in.valid;
   assign pop  = (count_ff != '0) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff    <= rd_ptr_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_in.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < WORDS_OUT; i++) begin
            words_ff[i] <= (i < COORDS_PER_POINT) ?
                           queue_ff[rd_ptr_ff][WORD_W*i +: WORD_W] : '0;
         end
      end
   end

   assign back_stat.push_ready = (count_ff != QUEUE_FULL);
   assign back_stat.drained    = (count_ff == '0) && !rsp_valid_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_x_bits = words_ff[0];
   assign rsp_y_bits = words_ff[1];
   assign rsp_z_bits = words_ff[2];

endmodule

FILE: tb/base64_point_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the base64 point decoder core
// Feeds base64 character words through a bursty driver and collects decoded
// points through a monitor with its own stall pattern. A behavioral decoder
// predicts every point and the monitor compares each field in order.
// ----------------------------------------------------------------------------
module base64_point_decoder_core_tb;
   import b64pd_pkg::*;

   localparam int COORDS       = 3;
   localparam int RANDOM_WORDS = 1500;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_word_t;

   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } point_words_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                req_message_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORD_W-1:0]   rsp_x_bits;
   logic [WORD_W-1:0]   rsp_y_bits;
   logic [WORD_W-1:0]   rsp_z_bits;

   char_word_t          pending_chars[$];
   point_words_t        expected_points[$];
   logic [SEXTET_W-1:0] held_sextets[0:STORE_DEPTH-1];
   logic [POS_W-1:0]    fill_count = '0;
   int                  error_count = 0;
   int                  burst_left = 1;
   int                  gap_left = 0;
   int                  rsp_cycle = 0;
   int                  stall_mode = 0;
   string               alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   base64_point_decoder_core #(
      .COORDS_PER_POINT(COORDS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_message_end(req_message_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_x_bits     (rsp_x_bits),
      .rsp_y_bits     (rsp_y_bits),
      .rsp_z_bits     (rsp_z_bits)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [SEXTET_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] v;
      v = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         v = c - CHAR_UPPER_A;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         v = c - CHAR_LOWER_A + 8'd26;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         v = c - CHAR_DIGIT_0 + 8'd52;
      end else if (c == CHAR_PLUS) begin
         v = 8'd62;
      end else if (c == CHAR_SLASH) begin
         v = 8'd63;
      end
      return v[SEXTET_W-1:0];
   endfunction

   // The sixteen sextets, first one most significant, form twelve bytes in
   // order; each output word takes four of them with the first byte lowest.
   task automatic absorb_char(input logic [CHAR_W-1:0] code, input logic last);
      logic [SEXTET_W-1:0] sx;
      logic [GROUP_BITS-1:0] group_bits;
      logic [WORD_W-1:0] words[0:WORDS_OUT-1];
      point_words_t pt;
      sx = sextet_of(code);
      if (fill_count < LAST_POS) begin
         held_sextets[fill_count] = sx;
         fill_count = fill_count + 1'b1;
      end else begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            group_bits[GROUP_BITS-1-SEXTET_W*i -: SEXTET_W] = held_sextets[i];
         end
         group_bits[SEXTET_W-1:0] = sx;
         for (int w = 0; w < WORDS_OUT; w++) begin
            for (int k = 0; k < 4; k++) begin
               words[w][8*k +: 8] = group_bits[GROUP_BITS-1-8*(4*w+k) -: 8];
            end
            if (w >= COORDS) begin
               words[w] = '0;
            end
         end
         pt.x = words[0];
         pt.y = words[1];
         pt.z = words[2];
         expected_points.push_back(pt);
         fill_count = '0;
      end
      if (last) begin
         fill_count = '0;
      end
   endtask

   task automatic queue_char(input logic [CHAR_W-1:0] code, input logic last);
      char_word_t cw;
      cw.code = code;
      cw.last = last;
      pending_chars.push_back(cw);
   endtask

   task automatic report_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         if (error_count <= REPORT_MAX) begin
            $display("Mismatch on %s: expected %h, got %h", name, exp_v, act_v);
         end
      end
   endtask

   always @(posedge clock) begin : drive_chars
      char_word_t next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            absorb_char(req_char_code, req_message_end);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            next_word = pending_chars.pop_front();
            req_char_code   <= next_word.code;
            req_message_end <= next_word.last;
            req_valid       <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : collect_points
      point_words_t exp_pt;
      logic next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("Unexpected point: x %h y %h z %h",
                           rsp_x_bits, rsp_y_bits, rsp_z_bits);
               end
            end else begin
               exp_pt = expected_points.pop_front();
               report_field("x_bits", exp_pt.x, rsp_x_bits);
               report_field("y_bits", exp_pt.y, rsp_y_bits);
               report_field("z_bits", exp_pt.z, rsp_z_bits);
            end
         end
         rsp_cycle++;
         if (rsp_cycle % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: begin
               next_ready = 1'b1;
            end
            1: begin
               next_ready = (rsp_cycle % 4) != 3;
            end
            2: begin
               next_ready = 1'($urandom_range(0, 1));
            end
            default: begin
               next_ready = (rsp_cycle % 32) == 0;
            end
         endcase
         rsp_ready <= next_ready;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("base64_point_decoder_core_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int kind;
      int len;
      int added;
      // Directed group: alphabet edges, padding, DEL, high codes, closed by
      // a message end on the sixteenth character.
      queue_char(8'h00, 1'b0);
      queue_char("A", 1'b0);
      queue_char("Z", 1'b0);
      queue_char("a", 1'b0);
      queue_char("z", 1'b0);
      queue_char("0", 1'b0);
      queue_char("9", 1'b0);
      queue_char("+", 1'b0);
      queue_char("/", 1'b0);
      queue_char("=", 1'b0);
      queue_char(8'h7F, 1'b0);
      queue_char(8'h80, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char("/", 1'b0);
      queue_char("+", 1'b0);
      queue_char("Q", 1'b1);
      // A short message that ends inside a group is dropped.
      queue_char("a", 1'b0);
      queue_char("b", 1'b0);
      queue_char("/", 1'b0);
      queue_char("+", 1'b0);
      queue_char("9", 1'b1);

      added = 0;
      while (added < RANDOM_WORDS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            len = 16 * $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               queue_char(alphabet[$urandom_range(0, 63)], i == len - 1);
            end
         end else if (kind == 7) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
               queue_char(alphabet[$urandom_range(0, 63)], i == len - 1);
            end
         end else if (kind == 8) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
               queue_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
         end else begin
            len = 16;
            for (int i = 0; i < len; i++) begin
               queue_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
            end
         end
         added += len;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_valid) @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      error_count += expected_points.size();
      if (error_count == 0) begin
         $display("base64_point_decoder_core_tb OK");
      end else begin
         $display("base64_point_decoder_core_tb NOT OK");
      end
      $finish;
   end

endmodule
